// ===== src/apr_pkg.sv =====
// shared types and constants for the aging page replacement block
`default_nettype none
package apr_pkg;

  localparam int unsigned AGE_W     = 8;
  localparam int unsigned AGE_TOP   = 7;
  localparam int unsigned PAGE_IN_W = 16;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_W     = 5;

  localparam logic [AGE_W-1:0] AGE_MSB   = AGE_W'(1) << AGE_TOP;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CFG_W-1:0] ACT_RESET = CFG_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIX  = 3'b100
  } state_t;

  typedef struct packed {
    logic hit;
    logic empty;
  } scan_flags_t;

endpackage
`default_nettype wire

// ===== src/apr_ifs.sv =====
// valid/ready channel interfaces for the reference, result and config ports
`default_nettype none
interface apr_in_if import apr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_IN_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface apr_out_if import apr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [IDX_OUT_W-1:0] frame_index;
  logic                 evicted;
  logic [PAGE_IN_W-1:0] evicted_page;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;

  modport source (output valid, output hit, output frame_index, output evicted,
                  output evicted_page, output hit_total, output miss_total,
                  input ready);
  modport sink (input valid, input hit, input frame_index, input evicted,
                input evicted_page, input hit_total, input miss_total,
                output ready);
endinterface

interface apr_cfg_if import apr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] active_frames;

  modport source (output valid, output active_frames, input ready);
  modport sink (input valid, input active_frames, output ready);
endinterface
`default_nettype wire

// ===== src/apr_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module apr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/apr_scan.sv =====
// per-frame scan unit: first match, first empty frame and oldest frame
`default_nettype none
module apr_scan import apr_pkg::*; #(
  parameter int unsigned FW = 4,
  parameter int unsigned PW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             ent_vld,
  input  wire logic [FW-1:0]    ent_idx,
  input  wire logic             ent_valid,
  input  wire logic [PW-1:0]    ent_page,
  input  wire logic [AGE_W-1:0] ent_age,
  input  wire logic [PW-1:0]    key,
  output scan_flags_t           flags,
  output logic      [FW-1:0]    hit_idx,
  output logic      [AGE_W-1:0] hit_age,
  output logic      [FW-1:0]    empty_idx,
  output logic      [FW-1:0]    min_idx,
  output logic      [PW-1:0]    min_page
);

  logic             have_min;
  logic [AGE_W-1:0] min_age;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags    <= '0;
      have_min <= 1'b0;
    end else if (ent_vld) begin
      if (!flags.hit && ent_valid && ent_page == key) begin
        flags.hit <= 1'b1;
        hit_idx   <= ent_idx;
        hit_age   <= ent_age;
      end
      if (!flags.empty && !ent_valid) begin
        flags.empty <= 1'b1;
        empty_idx   <= ent_idx;
      end
      // strict compare keeps the lowest frame on an age tie
      if (!have_min || ent_age < min_age) begin
        have_min <= 1'b1;
        min_age  <= ent_age;
        min_idx  <= ent_idx;
        min_page <= ent_page;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/aging_page_replacement_top.sv =====
// top level of the aging page replacement block: sequencer, frame store, counters
`default_nettype none
// Once a page reference is accepted, the block stays busy until its result is
// loaded. The sequencer walks the active frames of the frame ram one frame per
// cycle through its single read port, feeding the scan unit and writing each
// aged entry back in the cycle after its read. It then drains the last read
// through the scan, and a final step writes the chosen frame and loads the
// result register. The reference port is ready again in the same cycle that the
// result becomes valid, so a new reference is taken only once the last one is
// through. A result waits in its register until taken while the next reference
// is accepted and scanned; that reference's final step stalls until the result
// register is free. Page numbers and ages live in ram with no reset; per-frame
// valid bits are cleared by reset, so no clearing pass is needed. The active
// frame count is to be written on the config port only while the block is
// idle; the block itself does not enforce this. 0 acts as 1 and values above
// MAX_FRAMES act as MAX_FRAMES.
module aging_page_replacement_top import apr_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input wire logic clk,
  input wire logic rst,
  apr_in_if.sink    in_ch,
  apr_out_if.source out_ch,
  apr_cfg_if.sink   cfg
);

  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned EW = PAGE_BITS + AGE_W;

  state_t                  state;
  logic [CFG_W-1:0]        act;
  logic [31:0]             act_w;
  logic [CW-1:0]           nfr;
  logic [PAGE_BITS-1:0]    key;
  logic [MAX_FRAMES-1:0]   fvalid;
  logic [CW-1:0]           rd_idx;
  logic                    pend;
  logic [FW-1:0]           pend_idx;
  logic [EW-1:0]           rdata;
  logic [PAGE_BITS-1:0]    rd_page;
  logic [AGE_W-1:0]        rd_age;
  logic                    we;
  logic [FW-1:0]           waddr;
  logic [EW-1:0]           wdata;
  scan_flags_t             flags;
  logic [FW-1:0]           hit_idx;
  logic [AGE_W-1:0]        hit_age;
  logic [FW-1:0]           empty_idx;
  logic [FW-1:0]           min_idx;
  logic [PAGE_BITS-1:0]    min_page;
  logic [FW-1:0]           used;
  logic [AGE_W-1:0]        fix_age;
  logic                    out_free;
  logic                    do_fix;
  logic [CNT_W-1:0]        hit_cnt;
  logic [CNT_W-1:0]        miss_cnt;
  logic                    out_valid;
  logic                    out_hit;
  logic [IDX_OUT_W-1:0]    out_idx;
  logic                    out_evicted;
  logic [PAGE_IN_W-1:0]    out_ev_page;

  // clamp the register to 1..MAX_FRAMES
  assign act_w = 32'(act);
  always_comb begin
    if (act == '0) begin
      nfr = CW'(1);
    end else if (act_w > 32'(MAX_FRAMES)) begin
      nfr = CW'(MAX_FRAMES);
    end else begin
      nfr = CW'(act_w);
    end
  end

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= ACT_RESET;
    end else if (cfg.valid) begin
      act <= cfg.active_frames;
    end
  end

  assign rd_page = rdata[EW-1:AGE_W];
  // a never-filled frame always carries age zero
  assign rd_age  = fvalid[pend_idx] ? rdata[AGE_W-1:0] : '0;

  assign used     = flags.hit ? hit_idx : (flags.empty ? empty_idx : min_idx);
  assign fix_age  = flags.hit ? ((hit_age >> 1) | AGE_MSB) : AGE_MSB;
  assign out_free = !out_valid || out_ch.ready;
  assign do_fix   = (state == ST_FIX) && out_free;

  assign we    = ((state == ST_SCAN) && pend) || do_fix;
  assign waddr = do_fix ? used : pend_idx;
  assign wdata = do_fix ? {key, fix_age} : {rd_page, rd_age >> 1};

  apr_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[FW-1:0]),
    .rdata (rdata)
  );

  apr_scan #(
    .FW (FW),
    .PW (PAGE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ST_IDLE),
    .ent_vld   ((state == ST_SCAN) && pend),
    .ent_idx   (pend_idx),
    .ent_valid (fvalid[pend_idx]),
    .ent_page  (rd_page),
    .ent_age   (rd_age),
    .key       (key),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .hit_age   (hit_age),
    .empty_idx (empty_idx),
    .min_idx   (min_idx),
    .min_page  (min_page)
  );

  assign in_ch.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fvalid    <= '0;
      rd_idx    <= '0;
      pend      <= 1'b0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (do_fix) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            key    <= PAGE_BITS'(in_ch.page_number);
            rd_idx <= '0;
            pend   <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_idx < nfr) begin
            pend     <= 1'b1;
            pend_idx <= rd_idx[FW-1:0];
            rd_idx   <= rd_idx + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_FIX;
            end
          end
        end
        ST_FIX: begin
          if (out_free) begin
            fvalid[used] <= 1'b1;
            if (flags.hit) begin
              if (hit_cnt != CNT_MAX) begin
                hit_cnt <= hit_cnt + 1'b1;
              end
            end else if (miss_cnt != CNT_MAX) begin
              miss_cnt <= miss_cnt + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload; the counters feed the port directly and already include this reference once the result is valid
  always_ff @(posedge clk) begin
    if (do_fix) begin
      out_hit     <= flags.hit;
      out_idx     <= IDX_OUT_W'(used);
      out_evicted <= !flags.hit && !flags.empty;
      out_ev_page <= (!flags.hit && !flags.empty) ? PAGE_IN_W'(min_page) : '0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.hit          = out_hit;
  assign out_ch.frame_index  = out_idx;
  assign out_ch.evicted      = out_evicted;
  assign out_ch.evicted_page = out_ev_page;
  assign out_ch.hit_total    = hit_cnt;
  assign out_ch.miss_total   = miss_cnt;

`ifndef SYNTH
  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((fvalid & $past(fvalid)) == $past(fvalid)))
    else $error("frame valid bit dropped");

  a_fix_result: assert property (@(posedge clk) disable iff (rst)
    do_fix |=> (out_valid && state == ST_IDLE))
    else $error("final step did not deliver a result");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit reported with an eviction");
`endif

endmodule
`default_nettype wire
